// File: rtl/core/fmq_pkg.sv
// Shared types, constants and pointer helpers for the running-minimum FIFO.
// Used by fmq_front, fmq_back and fifo_with_running_minimum_unit.
`default_nettype none

package fmq_pkg;

    localparam int DEPTH  = 1024;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int PTR_W  = SLOT_W + 1;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 11;

    localparam logic [1:0] ACT_ENQ   = 2'd0;
    localparam logic [1:0] ACT_DEQ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_PEEK  = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] value;
    } req_t;

    // min deque entry: ring slot plus a copy of its value
    typedef struct packed {
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] value;
    } dq_entry_t;

    // pointers run modulo 2*DEPTH
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(2 * DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(2 * DEPTH - 1) : p - PTR_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] s;
        s = (p >= PTR_W'(DEPTH)) ? p - PTR_W'(DEPTH) : p;
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] tail,
                                                  input logic [PTR_W-1:0] head);
        return (tail >= head) ? tail - head : tail + PTR_W'(2 * DEPTH) - head;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fifo_with_running_minimum_unit.sv
// Top level of the running-minimum FIFO: request queue plus execution back end.
// Depends on fmq_pkg, fmq_front and fmq_back.
//
// Usage:
//   Requests come in on in_valid/in_ready with action (enqueue, dequeue, clear,
//   peek) and value. Every request yields exactly one result on
//   out_valid/out_ready: status, popped_value, front_value, min_value, count
//   and is_empty, in request order.
//   A two-entry request queue sits in front of the back end, which runs one
//   request at a time through one-write one-read value and min-deque memories.
//   Peek, clear, full enqueue and empty dequeue run idle, fetch, load; a dequeue
//   adds a DEQ step before fetch, and an enqueue adds an APPEND step, preceded by
//   one compare step per deque tail entry the new value removes and one more when
//   the scan stops on a smaller entry (removals amortize to at most one per
//   enqueue). An idle back end takes a request the cycle after it is accepted.
//   Reset clears the pointers and the control state; memory contents are left
//   as they are, so no clearing pass is needed.
//   A result waits in the output register while out_ready is low; the back
//   end completes the next request and holds at its final step, and the front
//   keeps taking requests until its two entries are full.
`default_nettype none

module fifo_with_running_minimum_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        action,
    input  wire logic signed [fmq_pkg::DATA_W-1:0] value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [1:0]                             status,
    output logic signed [fmq_pkg::DATA_W-1:0]      popped_value,
    output logic signed [fmq_pkg::DATA_W-1:0]      front_value,
    output logic signed [fmq_pkg::DATA_W-1:0]      min_value,
    output logic [fmq_pkg::CNT_W-1:0]              count,
    output logic                                   is_empty
);

    logic          req_valid;
    logic          req_ready;
    fmq_pkg::req_t req;

    fmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .value     (value),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    fmq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .front_value  (front_value),
        .min_value    (min_value),
        .count        (count),
        .is_empty     (is_empty)
    );

    a_min_le_front: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_empty |-> min_value <= front_value)
        else $error("min above front");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> count == '0 && front_value == '0 && min_value == '0)
        else $error("empty result not zeroed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= fmq_pkg::CNT_W'(fmq_pkg::DEPTH) && (is_empty == (count == '0)))
        else $error("count out of range");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == fmq_pkg::STAT_FULL |-> count == fmq_pkg::CNT_W'(fmq_pkg::DEPTH))
        else $error("full error while not full");

endmodule

`default_nettype wire

// File: rtl/core/fmq_front.sv
// Front end: takes requests, decodes them and holds up to two in a small queue.
// Depends on fmq_pkg.
`default_nettype none

module fmq_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    action,
    input  wire logic signed [fmq_pkg::DATA_W-1:0] value,
    output logic                               req_valid,
    input  wire logic                          req_ready,
    output fmq_pkg::req_t                      req
);

    fmq_pkg::req_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    fmq_pkg::req_t dec_req;
    logic          push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = req_valid && req_ready;

    // value only matters for an enqueue
    always_comb
    begin
        dec_req.action = action;
        dec_req.value  = (action == fmq_pkg::ACT_ENQ) ? value : '0;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= dec_req;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fmq_back.sv
// Back end: value ring, monotonic min deque, sequencer and result register.
// Depends on fmq_pkg.
`default_nettype none

module fmq_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire fmq_pkg::req_t                 req,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         status,
    output logic signed [fmq_pkg::DATA_W-1:0]  popped_value,
    output logic signed [fmq_pkg::DATA_W-1:0]  front_value,
    output logic signed [fmq_pkg::DATA_W-1:0]  min_value,
    output logic [fmq_pkg::CNT_W-1:0]          count,
    output logic                               is_empty
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CMP    = 3'd1;
    localparam logic [2:0] ST_APPEND = 3'd2;
    localparam logic [2:0] ST_DEQ    = 3'd3;
    localparam logic [2:0] ST_FETCH  = 3'd4;
    localparam logic [2:0] ST_LOAD   = 3'd5;

    logic signed [fmq_pkg::DATA_W-1:0] vmem [fmq_pkg::DEPTH];
    fmq_pkg::dq_entry_t                dmem [fmq_pkg::DEPTH];

    logic                              v_we;
    logic [fmq_pkg::SLOT_W-1:0]        v_waddr, v_raddr;
    logic signed [fmq_pkg::DATA_W-1:0] v_wdata, v_rdata;
    logic                              d_we;
    logic [fmq_pkg::SLOT_W-1:0]        d_waddr, d_raddr;
    fmq_pkg::dq_entry_t                d_wdata, d_rdata;

    logic [2:0]                 state_reg, state_next;
    logic [fmq_pkg::PTR_W-1:0]  head_reg, head_next;
    logic [fmq_pkg::PTR_W-1:0]  tail_reg, tail_next;
    logic [fmq_pkg::PTR_W-1:0]  mhead_reg, mhead_next;
    logic [fmq_pkg::PTR_W-1:0]  mtail_reg, mtail_next;
    logic [fmq_pkg::PTR_W-1:0]  cnt_cur, mtail_dec;

    logic signed [fmq_pkg::DATA_W-1:0] val_reg, val_next;
    logic [fmq_pkg::SLOT_W-1:0]        enq_slot_reg, enq_slot_next;
    logic [1:0]                        stat_reg, stat_next;
    logic signed [fmq_pkg::DATA_W-1:0] pop_reg, pop_next;

    logic                              out_valid_reg, out_valid_next;
    logic                              load;
    logic [1:0]                        status_reg;
    logic signed [fmq_pkg::DATA_W-1:0] popped_reg, front_reg, min_reg;
    logic [fmq_pkg::CNT_W-1:0]         count_reg;
    logic                              empty_reg;

    assign req_ready    = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign front_value  = front_reg;
    assign min_value    = min_reg;
    assign count        = count_reg;
    assign is_empty     = empty_reg;

    assign cnt_cur   = fmq_pkg::ptr_dist(tail_reg, head_reg);
    assign mtail_dec = fmq_pkg::ptr_dec(mtail_reg);
    assign load      = (state_reg == ST_LOAD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        mhead_next    = mhead_reg;
        mtail_next    = mtail_reg;
        val_next      = val_reg;
        enq_slot_next = enq_slot_reg;
        stat_next     = stat_reg;
        pop_next      = pop_reg;
        v_we          = 1'b0;
        v_waddr       = fmq_pkg::ptr_slot(tail_reg);
        v_wdata       = req.value;
        v_raddr       = fmq_pkg::ptr_slot(head_reg);
        d_we          = 1'b0;
        d_waddr       = fmq_pkg::ptr_slot(mtail_reg);
        d_wdata.slot  = enq_slot_reg;
        d_wdata.value = val_reg;
        d_raddr       = fmq_pkg::ptr_slot(mhead_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    stat_next = fmq_pkg::STAT_OK;
                    pop_next  = '0;
                    state_next = ST_FETCH;
                    case (req.action)
                        fmq_pkg::ACT_ENQ:
                        begin
                            if (cnt_cur >= fmq_pkg::PTR_W'(fmq_pkg::DEPTH))
                            begin
                                stat_next = fmq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                v_we          = 1'b1;
                                tail_next     = fmq_pkg::ptr_inc(tail_reg);
                                enq_slot_next = fmq_pkg::ptr_slot(tail_reg);
                                val_next      = req.value;
                                if (mtail_reg != mhead_reg)
                                begin
                                    d_raddr    = fmq_pkg::ptr_slot(mtail_dec);
                                    state_next = ST_CMP;
                                end
                                else
                                begin
                                    state_next = ST_APPEND;
                                end
                            end
                        end
                        fmq_pkg::ACT_DEQ:
                        begin
                            if (cnt_cur == '0)
                            begin
                                stat_next = fmq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_DEQ;
                            end
                        end
                        fmq_pkg::ACT_CLEAR:
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            mhead_next = '0;
                            mtail_next = '0;
                        end
                        default:
                        begin
                            if (cnt_cur == '0)
                            begin
                                stat_next = fmq_pkg::STAT_EMPTY;
                            end
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                // drop back entries that are not below the new value
                if (val_reg <= d_rdata.value)
                begin
                    mtail_next = mtail_dec;
                    if (mtail_dec != mhead_reg)
                    begin
                        d_raddr = fmq_pkg::ptr_slot(fmq_pkg::ptr_dec(mtail_dec));
                    end
                    else
                    begin
                        state_next = ST_APPEND;
                    end
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                d_we       = 1'b1;
                mtail_next = fmq_pkg::ptr_inc(mtail_reg);
                state_next = ST_FETCH;
            end
            ST_DEQ:
            begin
                pop_next  = v_rdata;
                head_next = fmq_pkg::ptr_inc(head_reg);
                if ((mhead_reg != mtail_reg) && (d_rdata.slot == fmq_pkg::ptr_slot(head_reg)))
                begin
                    mhead_next = fmq_pkg::ptr_inc(mhead_reg);
                end
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            mhead_reg     <= '0;
            mtail_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            mhead_reg     <= mhead_next;
            mtail_reg     <= mtail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        enq_slot_reg <= enq_slot_next;
        stat_reg     <= stat_next;
        pop_reg      <= pop_next;
        if (load)
        begin
            status_reg <= stat_reg;
            popped_reg <= pop_reg;
            count_reg  <= fmq_pkg::CNT_W'(cnt_cur);
            empty_reg  <= (cnt_cur == '0);
            front_reg  <= (cnt_cur == '0) ? '0 : v_rdata;
            min_reg    <= (cnt_cur == '0) ? '0 : d_rdata.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vmem[v_waddr] <= v_wdata;
        end
        v_rdata <= vmem[v_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            dmem[d_waddr] <= d_wdata;
        end
        d_rdata <= dmem[d_raddr];
    end

endmodule

`default_nettype wire

// File: tb/running_min_checker.sv
// Scoreboard for fifo_with_running_minimum_unit: watches both channels, predicts each result.
// Keeps its own copy of the value ring and the monotonic slot deque.
// Depends on fmq_pkg.
`default_nettype none

module running_min_checker
    import fmq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_ready,
    input  wire logic [1:0]               action,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic                     out_valid,
    input  wire logic                     out_ready,
    input  wire logic [1:0]               status,
    input  wire logic signed [DATA_W-1:0] popped_value,
    input  wire logic signed [DATA_W-1:0] front_value,
    input  wire logic signed [DATA_W-1:0] min_value,
    input  wire logic [CNT_W-1:0]         count,
    input  wire logic                     is_empty,
    output int                            mismatches,
    output int                            outstanding
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] popped;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] minv;
        logic [CNT_W-1:0]         cnt;
        logic                     empty;
    } min_result_t;

    logic signed [DATA_W-1:0] ring_vals [DEPTH];
    int unsigned              mono_slots [DEPTH];
    int unsigned              rd_ptr;
    int unsigned              wr_ptr;
    int unsigned              mq_rd;
    int unsigned              mq_wr;
    min_result_t              pending_results [$];
    int                       mismatch_total;
    int                       result_index;

    // pointers wrap at twice the ring size so that full and empty differ
    function automatic int unsigned step_ptr(input int unsigned p);
        return (p + 1 >= 2 * DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int unsigned back_ptr(input int unsigned p);
        return (p == 0) ? 2 * DEPTH - 1 : p - 1;
    endfunction

    function automatic int unsigned span(input int unsigned t, input int unsigned h);
        return (t + 2 * DEPTH - h) % (2 * DEPTH);
    endfunction

    function automatic min_result_t predict_request(input logic [1:0] act,
                                                    input logic signed [DATA_W-1:0] val);
        min_result_t r;
        int unsigned held;
        int unsigned s;
        r = '0;
        held = span(wr_ptr, rd_ptr);
        case (act)
            ACT_ENQ:
            begin
                if (held >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    s = wr_ptr % DEPTH;
                    ring_vals[s] = val;
                    wr_ptr = step_ptr(wr_ptr);
                    // drop tail slots whose value is not below the new one
                    while (span(mq_wr, mq_rd) > 0 &&
                           val <= ring_vals[mono_slots[back_ptr(mq_wr) % DEPTH]])
                        mq_wr = back_ptr(mq_wr);
                    mono_slots[mq_wr % DEPTH] = s;
                    mq_wr = step_ptr(mq_wr);
                end
            end
            ACT_DEQ:
            begin
                if (held == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    s = rd_ptr % DEPTH;
                    r.popped = ring_vals[s];
                    rd_ptr = step_ptr(rd_ptr);
                    if (span(mq_wr, mq_rd) > 0 && mono_slots[mq_rd % DEPTH] == s)
                        mq_rd = step_ptr(mq_rd);
                end
            end
            ACT_CLEAR:
            begin
                rd_ptr = 0;
                wr_ptr = 0;
                mq_rd  = 0;
                mq_wr  = 0;
            end
            default:
            begin
                if (held == 0)
                    r.status = STAT_EMPTY;
            end
        endcase
        held = span(wr_ptr, rd_ptr);
        if (held > 0) begin
            r.front = ring_vals[rd_ptr % DEPTH];
            r.minv  = ring_vals[mono_slots[mq_rd % DEPTH]];
        end
        r.cnt   = held[CNT_W-1:0];
        r.empty = (held == 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        min_result_t want;
        min_result_t got;
        if (!rst_n) begin
            rd_ptr = 0;
            wr_ptr = 0;
            mq_rd  = 0;
            mq_wr  = 0;
            pending_results.delete();
            mismatch_total = 0;
            result_index   = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            if (in_valid && in_ready)
                pending_results.push_back(predict_request(action, value));
            if (out_valid && out_ready) begin
                got = {status, popped_value, front_value, min_value, count, is_empty};
                if (pending_results.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= MAX_REPORTS)
                        $display("result %0d with no request waiting: status=%0d popped=%0d front=%0d min=%0d count=%0d empty=%0d",
                                 result_index, got.status, got.popped, got.front, got.minv,
                                 got.cnt, got.empty);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.popped !== want.popped ||
                        got.front !== want.front || got.minv !== want.minv ||
                        got.cnt !== want.cnt || got.empty !== want.empty) begin
                        mismatch_total++;
                        if (mismatch_total <= MAX_REPORTS) begin
                            $display("result %0d mismatch: expected status=%0d popped=%0d front=%0d min=%0d count=%0d empty=%0d",
                                     result_index, want.status, want.popped, want.front,
                                     want.minv, want.cnt, want.empty);
                            $display("result %0d mismatch: actual   status=%0d popped=%0d front=%0d min=%0d count=%0d empty=%0d",
                                     result_index, got.status, got.popped, got.front,
                                     got.minv, got.cnt, got.empty);
                        end
                    end
                end
                result_index++;
            end
            mismatches  <= mismatch_total;
            outstanding <= pending_results.size();
        end
    end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Stimulus and verdict for fifo_with_running_minimum_unit.
// Drives bursty requests and a stalling receiver; running_min_checker does the checking.
// Depends on fmq_pkg, running_min_checker and the RTL.
`default_nettype none

module tb_top;
    import fmq_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RISE_ITEMS   = 150;
    localparam int RANDOM_ITEMS = 226;
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_SPARSE, RDY_COIN} ready_mode_e;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               action = ACT_PEEK;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] min_value;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;

    int          fail_count;
    int          waiting_results;
    int          cycle_count = 0;
    int          burst_left = 4;
    ready_mode_e ready_mode = RDY_ALWAYS;
    int          mode_left = 0;

    always #5 clk = ~clk;

    fifo_with_running_minimum_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .front_value  (front_value),
        .min_value    (min_value),
        .count        (count),
        .is_empty     (is_empty)
    );

    running_min_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .front_value  (front_value),
        .min_value    (min_value),
        .count        (count),
        .is_empty     (is_empty),
        .mismatches   (fail_count),
        .outstanding  (waiting_results)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("fifo_with_running_minimum_unit verification failed");
            $finish;
        end
    end

    // receiver back-pressure, independent of the sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_mode <= RDY_ALWAYS;
            mode_left <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= ready_mode_e'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 96);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                RDY_ALWAYS: out_ready <= 1'b1;
                RDY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                RDY_SPARSE: out_ready <= (cycle_count % 5 == 0);
                default:    out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3, 4: return DATA_W'($signed($urandom_range(0, 15)) - 8);
            default: return $signed($urandom);
        endcase
    endfunction

    // call on a clock edge; returns on the edge where the request is taken, or after the idle gap that ends a burst
    task automatic send_req(input logic [1:0] act, input logic signed [DATA_W-1:0] val);
        int gap;
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        int          pick;
        logic [1:0]  act;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corner cases
        send_req(ACT_PEEK, 32'sd0);
        send_req(ACT_DEQ, VAL_MAX);
        send_req(ACT_CLEAR, VAL_MIN);
        // extremes, then equal minima
        send_req(ACT_ENQ, VAL_MAX);
        send_req(ACT_ENQ, VAL_MIN);
        send_req(ACT_ENQ, 32'sd0);
        send_req(ACT_ENQ, -32'sd1);
        send_req(ACT_ENQ, VAL_MIN);
        send_req(ACT_PEEK, -32'sd1);
        send_req(ACT_DEQ, 32'sd0);
        send_req(ACT_DEQ, 32'sd0);
        send_req(ACT_DEQ, 32'sd0);
        send_req(ACT_ENQ, 32'sd5);
        send_req(ACT_ENQ, 32'sd5);
        send_req(ACT_ENQ, 32'sd7);
        send_req(ACT_DEQ, 32'sd0);
        send_req(ACT_DEQ, 32'sd0);
        send_req(ACT_PEEK, VAL_MAX);
        send_req(ACT_CLEAR, -32'sd1);
        send_req(ACT_PEEK, 32'sd0);
        send_req(ACT_DEQ, 32'sd0);

        // strictly rising fill grows a long deque
        for (int i = 0; i < RISE_ITEMS; i++)
            send_req(ACT_ENQ, DATA_W'(i * 7 - 3000));
        send_req(ACT_PEEK, 32'sd0);
        // one new minimum sweeps the whole deque
        send_req(ACT_ENQ, VAL_MIN);
        send_req(ACT_DEQ, 32'sd0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 48)
                act = ACT_ENQ;
            else if (pick < 88)
                act = ACT_DEQ;
            else if (pick < 97)
                act = ACT_PEEK;
            else
                act = ACT_CLEAR;
            send_req(act, pick_value());
        end
        in_valid <= 1'b0;

        // let the checker count the last request before waiting on it
        @(posedge clk);
        while (waiting_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && waiting_results == 0)
            $display("fifo_with_running_minimum_unit verification clean");
        else
            $display("fifo_with_running_minimum_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/fmq_pkg.sv
rtl/core/fmq_front.sv
rtl/core/fmq_back.sv
rtl/core/fifo_with_running_minimum_unit.sv
tb/running_min_checker.sv
tb/tb_top.sv
